// ===== hdl/tct_pkg.sv =====
package tct_pkg;

	localparam int unsigned FlagW = 6;

	localparam logic [FlagW-1:0] FlagFin = 6'h01;
	localparam logic [FlagW-1:0] FlagSyn = 6'h02;
	localparam logic [FlagW-1:0] FlagRst = 6'h04;
	localparam logic [FlagW-1:0] FlagAck = 6'h10;

	localparam logic [7:0] TimeoutReset = 8'd10;

	typedef enum logic [2:0] {
		ST_CLOSED      = 3'd0,
		ST_SYN_SENT    = 3'd1,
		ST_SYN_RCVD    = 3'd2,
		ST_ESTABLISHED = 3'd3,
		ST_FIN_WAIT_1  = 3'd4,
		ST_CLOSE_WAIT  = 3'd5,
		ST_AWAIT_ACK   = 3'd6,
		ST_LINGER      = 3'd7
	} conn_state_t;

	typedef struct packed {
		logic             action;
		logic [FlagW-1:0] flags;
		logic             from_server;
	} item_t;

	typedef struct packed {
		logic        forward;
		conn_state_t session_state;
	} result_t;

endpackage

// ===== hdl/tcp_connection_tracker.sv =====
// Tracks the TCP state of one proxied session. Each input beat is either an observed
// segment (tuser low: tdata carries the flags byte and the direction) or a one-second
// tick (tuser high). Every input beat yields exactly one output beat with the forward
// decision and the session state after the beat. The block takes a beat every cycle
// unless the output side stalls: a beat goes into an input register, the flag decode
// and timeout counter update act on that register and the result lands in the output
// register. The user must write the linger timeout (seconds, reset 10) through
// cfg_wr_en / cfg_wr_data only while no beats are in flight; it is not enforced.
module tcp_connection_tracker
	import tct_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // flags[7:0], from_server[8], zero pad
	input  logic        s_axis_tuser,  // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata   // forward[0], session_state[3:1], zero pad
);

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t out_q;
	result_t result;
	logic    advance;
	logic    step;

	assign advance       = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) valid_s1 <= s_axis_tvalid;
			if (advance) out_valid_q <= valid_s1;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.action      <= s_axis_tuser;
			item_s1.flags       <= s_axis_tdata[FlagW-1:0];
			item_s1.from_server <= s_axis_tdata[8];
		end
		if (step) out_q <= result;
	end

	tct_fsm u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step        (step),
		.item        (item_s1),
		.result      (result)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, out_q.session_state, out_q.forward};

endmodule

// ===== hdl/tct_fsm.sv =====
module tct_fsm
	import tct_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       step,
	input  item_t      item,
	output result_t    result
);

	conn_state_t conn_state_q;
	conn_state_t state_nxt;
	logic [7:0]  wait_left_q;
	logic [7:0]  wait_nxt;
	logic [7:0]  timeout_q;
	logic        fwd;
	logic        syn;
	logic        ack;
	logic        fin;

	assign syn = |(item.flags & FlagSyn);
	assign ack = |(item.flags & FlagAck);
	assign fin = |(item.flags & FlagFin);

	always_comb begin
		state_nxt = conn_state_q;
		wait_nxt  = wait_left_q;
		fwd       = 1'b0;
		if (item.action) begin
			// one second gone by
			if (conn_state_q == ST_LINGER) begin
				if (wait_left_q <= 8'd1) begin
					wait_nxt  = '0;
					state_nxt = ST_CLOSED;
				end else begin
					wait_nxt = wait_left_q - 8'd1;
				end
			end
		end else if (item.flags == FlagRst) begin
			fwd       = 1'b1;
			state_nxt = ST_CLOSED;
		end else if (item.flags == FlagSyn &&
				!(conn_state_q inside {ST_SYN_SENT, ST_SYN_RCVD})) begin
			// pure syn outside the handshake restarts the session, or closes it when from the server
			fwd       = 1'b1;
			state_nxt = item.from_server ? ST_CLOSED : ST_SYN_SENT;
		end else begin
			fwd = 1'b1;
			case (conn_state_q)
				ST_CLOSED: begin
					if (syn && !item.from_server) state_nxt = ST_SYN_SENT;
				end
				ST_SYN_SENT: begin
					if (syn && ack && item.from_server) state_nxt = ST_SYN_RCVD;
				end
				ST_SYN_RCVD: begin
					if (ack && !item.from_server) state_nxt = ST_ESTABLISHED;
				end
				ST_ESTABLISHED: begin
					if (fin && !item.from_server) state_nxt = ST_FIN_WAIT_1;
				end
				ST_FIN_WAIT_1: begin
					if (ack && fin && item.from_server) state_nxt = ST_AWAIT_ACK;
					else if (ack && item.from_server) state_nxt = ST_CLOSE_WAIT;
				end
				ST_CLOSE_WAIT: begin
					if (fin && item.from_server) state_nxt = ST_AWAIT_ACK;
				end
				ST_AWAIT_ACK: begin
					if (ack && !item.from_server) begin
						state_nxt = ST_LINGER;
						wait_nxt  = timeout_q;
					end
				end
				default: begin
					fwd = 1'b0;
				end
			endcase
		end
	end

	assign result.forward       = fwd;
	assign result.session_state = state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conn_state_q <= ST_CLOSED;
			wait_left_q  <= '0;
			timeout_q    <= TimeoutReset;
		end else begin
			if (cfg_wr_en) timeout_q <= cfg_wr_data;
			if (step) begin
				conn_state_q <= state_nxt;
				wait_left_q  <= wait_nxt;
			end
		end
	end

`ifndef SYNTHESIS
	a_linger_from_await_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(conn_state_q == ST_LINGER && $past(conn_state_q) != ST_LINGER)
			|-> $past(conn_state_q) == ST_AWAIT_ACK)
		else $error("linger entered from a state other than await ack");

	a_tick_outside_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item.action && conn_state_q != ST_LINGER)
			|=> $stable(conn_state_q) && $stable(wait_left_q))
		else $error("tick changed state outside linger");

	a_no_step_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(conn_state_q) && $stable(wait_left_q))
		else $error("session state moved without a beat");

	a_tick_not_forwarded: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item.action) |-> !result.forward)
		else $error("tick produced a forwarded result");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import tct_pkg::*;

	localparam int CycleLimit = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = 8'd0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = 16'd0;  // flags[7:0], from_server[8], zero pad
	logic        s_axis_tuser = 1'b0;   // action
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b1;
	logic [7:0]  m_axis_tdata;          // forward[0], session_state[3:1], zero pad

	// tracker copy used for prediction
	conn_state_t trk_state = ST_CLOSED;
	logic [7:0]  trk_wait = 8'd0;
	logic [7:0]  trk_timeout = TimeoutReset;

	result_t pending_results[$];
	bit      idle_on = 1'b1;
	int      stall_left = 0;
	int      cycle_count = 0;
	int      fail_count = 0;

	tcp_connection_tracker uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 0;
	end

	function automatic result_t next_session_result(input logic act, input logic [7:0] fl8,
			input logic srv);
		result_t          r;
		logic [FlagW-1:0] fl;
		logic             syn;
		logic             ack;
		logic             fin;
		fl  = fl8[FlagW-1:0];
		syn = (fl & FlagSyn) != 0;
		ack = (fl & FlagAck) != 0;
		fin = (fl & FlagFin) != 0;
		r.forward = 1'b0;
		if (act) begin
			if (trk_state == ST_LINGER) begin
				if (trk_wait <= 8'd1) begin
					trk_wait  = 8'd0;
					trk_state = ST_CLOSED;
				end else begin
					trk_wait = trk_wait - 8'd1;
				end
			end
		end else begin
			r.forward = 1'b1;
			// pure rst and pure syn win over the linger drop
			if (fl == FlagRst) begin
				trk_state = ST_CLOSED;
			end else if (fl == FlagSyn && trk_state != ST_SYN_SENT
					&& trk_state != ST_SYN_RCVD) begin
				trk_state = srv ? ST_CLOSED : ST_SYN_SENT;
			end else begin
				case (trk_state)
					ST_CLOSED: if (syn && !srv) trk_state = ST_SYN_SENT;
					ST_SYN_SENT: if (syn && ack && srv) trk_state = ST_SYN_RCVD;
					ST_SYN_RCVD: if (ack && !srv) trk_state = ST_ESTABLISHED;
					ST_ESTABLISHED: if (fin && !srv) trk_state = ST_FIN_WAIT_1;
					ST_FIN_WAIT_1: begin
						if (ack && fin && srv) trk_state = ST_AWAIT_ACK;
						else if (ack && srv) trk_state = ST_CLOSE_WAIT;
					end
					ST_CLOSE_WAIT: if (fin && srv) trk_state = ST_AWAIT_ACK;
					ST_AWAIT_ACK: begin
						if (ack && !srv) begin
							trk_state = ST_LINGER;
							trk_wait  = trk_timeout;
						end
					end
					default: r.forward = 1'b0;
				endcase
			end
		end
		r.session_state = trk_state;
		return r;
	endfunction

	// valid stays high between back-to-back beats; it drops only for a gap
	task automatic send_beat(input logic act, input logic [7:0] fl, input logic srv);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= {7'd0, srv, fl};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_results.push_back(next_session_result(act, fl, srv));
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_timeout(input logic [7:0] v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		trk_timeout = v;
	endtask

	// the segment that moves the session one step further; in linger a tick, or now and then a random segment
	task automatic send_progress();
		logic [7:0] extra;
		logic       srv;
		extra = 8'($urandom_range(0, 255) & $urandom_range(0, 255));
		srv   = 1'($urandom_range(0, 1));
		case (trk_state)
			ST_CLOSED:      send_beat(1'b0, extra | FlagSyn, 1'b0);
			ST_SYN_SENT:    send_beat(1'b0, extra | FlagSyn | FlagAck, 1'b1);
			ST_SYN_RCVD:    send_beat(1'b0, extra | FlagAck, 1'b0);
			ST_ESTABLISHED: send_beat(1'b0, extra | FlagFin, 1'b0);
			ST_FIN_WAIT_1:  send_beat(1'b0, extra | FlagAck, 1'b1);
			ST_CLOSE_WAIT:  send_beat(1'b0, extra | FlagFin, 1'b1);
			ST_AWAIT_ACK:   send_beat(1'b0, extra | FlagAck, 1'b0);
			default: begin
				if ($urandom_range(0, 6) != 0) send_beat(1'b1, extra, srv);
				else send_beat(1'b0, extra, srv);
			end
		endcase
	endtask

	task automatic test_directed();
		send_beat(1'b1, 8'hff, 1'b1);   // tick while closed
		send_beat(1'b0, 8'h00, 1'b0);
		send_beat(1'b0, 8'hff, 1'b1);
		send_beat(1'b0, 8'hc2, 1'b1);   // pure syn from server once masked
		send_beat(1'b0, 8'hc2, 1'b0);
		send_beat(1'b0, 8'h02, 1'b0);   // pure syn inside handshake
		send_beat(1'b0, 8'h12, 1'b1);
		send_beat(1'b0, 8'h02, 1'b1);
		send_beat(1'b0, 8'h10, 1'b0);
		send_beat(1'b0, 8'h3f, 1'b1);
		send_beat(1'b0, 8'h01, 1'b0);
		send_beat(1'b0, 8'h10, 1'b1);
		send_beat(1'b0, 8'h01, 1'b1);
		send_beat(1'b0, 8'h10, 1'b0);
		send_beat(1'b0, 8'h10, 1'b0);   // dropped while lingering
		send_beat(1'b1, 8'h00, 1'b0);
		send_beat(1'b1, 8'h00, 1'b1);
		send_beat(1'b0, 8'h84, 1'b1);   // rst while lingering, counter left part-way
		send_beat(1'b0, 8'h02, 1'b0);
		send_beat(1'b0, 8'h12, 1'b1);
		send_beat(1'b0, 8'h10, 1'b0);
		send_beat(1'b0, 8'h01, 1'b0);
		send_beat(1'b0, 8'h11, 1'b1);
		send_beat(1'b0, 8'h50, 1'b0);
		send_beat(1'b0, 8'h02, 1'b1);   // server syn while lingering closes
	endtask

	task automatic test_wait_timeout();
		logic [7:0] setting [4];
		setting = '{8'd0, 8'd1, 8'd255, 8'($urandom_range(2, 30))};
		foreach (setting[i]) begin
			set_timeout(setting[i]);
			while (trk_state != ST_LINGER) send_progress();
			while (trk_state == ST_LINGER)
				send_beat(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			send_beat(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic test_random_sessions();
		logic [7:0] setting [4];
		int         pick;
		setting = '{8'($urandom_range(1, 15)), 8'd2, 8'($urandom_range(1, 15)), TimeoutReset};
		foreach (setting[p]) begin
			set_timeout(setting[p]);
			if (p == 3) idle_on = 1'b0;
			repeat (130) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					send_progress();
				end else if (pick < 80) begin
					send_beat(1'b0, {2'($urandom_range(0, 3)), pick[0] ? FlagRst : FlagSyn},
						1'($urandom_range(0, 1)));
				end else begin
					send_beat(1'($urandom_range(0, 3) == 0), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) stall_left--;
		else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 5);
		m_axis_tready <= (stall_left == 0);
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected, tdata %h", m_axis_tdata);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[0] !== want.forward) begin
					$error("forward: expected %0d, actual %0d", want.forward, m_axis_tdata[0]);
					fail_count++;
				end
				if (m_axis_tdata[3:1] !== want.session_state) begin
					$error("session_state: expected %0d, actual %0d",
						want.session_state, m_axis_tdata[3:1]);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_wait_timeout();
		test_random_sessions();
		drain();
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/tct_pkg.sv
hdl/tct_fsm.sv
hdl/tcp_connection_tracker.sv
tb/tb_top.sv
